FILE: rtl/rrs_pkg.sv
// Shared types, codes and constants of the RTP receiver statistics block.
package rrs_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int FRAC_BITS       = 8;
   localparam int FRAC_COUNT_WIDTH = $clog2(FRAC_BITS);

   typedef logic [1:0] func_type;
   localparam func_type FUNC_INIT   = 2'd0;
   localparam func_type FUNC_SEQ    = 2'd1;
   localparam func_type FUNC_JITTER = 2'd2;
   localparam func_type FUNC_LOSS   = 2'd3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_MAX_DROPOUT    = 2'd0;
   localparam csr_index_type CSR_MAX_MISORDER   = 2'd1;
   localparam csr_index_type CSR_MIN_SEQUENTIAL = 2'd2;

   localparam logic [15:0] RESET_MAX_DROPOUT    = 16'd3000;
   localparam logic [15:0] RESET_MAX_MISORDER   = 16'd100;
   localparam logic [7:0]  RESET_MIN_SEQUENTIAL = 8'd2;

   // A 17-bit value that no 16-bit sequence number can match.
   localparam logic [16:0] NO_SUSPECT = 17'h10001;
   localparam logic [16:0] SEQ_SPAN   = 17'h10000;

   typedef logic [3:0] op_type;
   localparam op_type OP_NONE          = 4'd0;
   localparam op_type OP_CAPTURE       = 4'd1;
   localparam op_type OP_INIT          = 4'd2;
   localparam op_type OP_SEQ           = 4'd3;
   localparam op_type OP_JIT_TRANSIT   = 4'd4;
   localparam op_type OP_JIT_DIFF      = 4'd5;
   localparam op_type OP_JIT_SUM       = 4'd6;
   localparam op_type OP_LOSS_EXPECT   = 4'd7;
   localparam op_type OP_LOSS_INTERVAL = 4'd8;
   localparam op_type OP_LOSS_LOST     = 4'd9;
   localparam op_type OP_LOSS_DECIDE   = 4'd10;
   localparam op_type OP_DIV_STORE     = 4'd11;
   localparam op_type OP_LOAD_OUT      = 4'd12;

   typedef struct packed {
      func_type    func;
      logic [31:0] source_id;
      logic [15:0] seq_number;
      logic [31:0] rtp_timestamp;
      logic [31:0] arrival_time;
   } req_payload_type;

   typedef struct packed {
      logic               status;
      logic [31:0]        source_ident;
      logic [31:0]        extended_max_seq;
      logic [31:0]        received_count;
      logic signed [31:0] cumulative_lost;
      logic [7:0]         loss_fraction;
      logic [31:0]        jitter_estimate;
   } rsp_payload_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } status_type;

endpackage

FILE: rtl/rrs_stream_if.sv
// Valid/ready stream interface used for the request and response channels.
interface rrs_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/rrs_fraction_div.sv
// Restoring divider that produces the 8-bit loss fraction one bit per cycle.
module rrs_fraction_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [rrs_pkg::FRAC_BITS-1:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [rrs_pkg::FRAC_BITS-1:0] quo_ff, quo_in;
   logic [rrs_pkg::FRAC_COUNT_WIDTH-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] rem_shift;
   logic        fits;

   // The dividend is always below the divisor, so the shifted remainder fits.
   assign rem_shift = {rem_ff[30:0], 1'b0};
   assign fits      = rem_shift >= div_ff;

   always_comb begin
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         rem_in   = dividend;
         div_in   = divisor;
         quo_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_shift - div_ff : rem_shift;
         quo_in   = {quo_ff[rrs_pkg::FRAC_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == rrs_pkg::FRAC_COUNT_WIDTH'(rrs_pkg::FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("divider remainder reached the divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider finished without raising done");

endmodule

FILE: rtl/rrs_datapath.sv
// Source state, configuration registers and arithmetic of the statistics block.
module rrs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  rrs_pkg::cmd_type         cmd,
   input  rrs_pkg::req_payload_type req_payload,
   input  logic                     csr_write_en,
   input  rrs_pkg::csr_index_type   csr_index,
   input  logic [rrs_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output rrs_pkg::status_type      status,
   output rrs_pkg::rsp_payload_type rsp_payload
);

   logic [15:0] max_dropout_ff, max_dropout_in;
   logic [15:0] max_misorder_ff, max_misorder_in;
   logic [7:0]  min_seq_ff, min_seq_in;

   rrs_pkg::req_payload_type item_ff, item_in;
   rrs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [31:0] ident_ff, ident_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] highest_ff, highest_in;
   logic [16:0] suspect_ff, suspect_in;
   logic [15:0] wrap_ff, wrap_in;
   logic [31:0] rx_total_ff, rx_total_in;
   logic [31:0] rx_before_ff, rx_before_in;
   logic [31:0] exp_before_ff, exp_before_in;
   logic [7:0]  prob_left_ff, prob_left_in;
   logic [31:0] last_transit_ff, last_transit_in;
   logic [31:0] jitter_ff, jitter_in;
   logic [31:0] lost_ff, lost_in;
   logic [7:0]  fraction_ff, fraction_in;
   logic        status_ff, status_in;

   logic [31:0] transit_ff, transit_in;
   logic [31:0] mag_ff, mag_in;
   logic [28:0] decay_ff, decay_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] exp_int_ff, exp_int_in;
   logic [31:0] rec_int_ff, rec_int_in;
   logic [31:0] lost_int_ff, lost_int_in;

   logic [15:0] seq;
   logic [15:0] hi_next;
   logic [15:0] udelta;
   logic [16:0] misorder_limit;
   logic [7:0]  prob_dec;
   logic [31:0] jit_diff;
   logic [32:0] jit_plus8;
   logic [32:0] jit_sum;
   logic        frac_zero;
   logic        need_div;
   logic        div_start;
   logic        div_done;
   logic [rrs_pkg::FRAC_BITS-1:0] div_quotient;

   assign seq            = item_ff.seq_number;
   assign hi_next        = highest_ff + 16'd1;
   assign udelta         = seq - highest_ff;
   assign misorder_limit = rrs_pkg::SEQ_SPAN - {1'b0, max_misorder_ff};
   assign prob_dec       = prob_left_ff - 8'd1;
   assign jit_diff       = transit_ff - last_transit_ff;
   assign jit_plus8      = {1'b0, jitter_ff} + 33'd8;
   assign jit_sum        = {1'b0, jitter_ff} + {1'b0, mag_ff} - {4'd0, decay_ff};

   // Interval values are read as signed; a fraction exists only when both are positive.
   assign frac_zero = exp_int_ff[31] || (exp_int_ff == 32'd0) ||
                      lost_int_ff[31] || (lost_int_ff == 32'd0);
   assign need_div  = !frac_zero && (lost_int_ff < exp_int_ff);
   assign div_start = (cmd.op == rrs_pkg::OP_LOSS_DECIDE) && need_div;

   rrs_fraction_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lost_int_ff),
      .divisor  (exp_int_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      max_dropout_in  = max_dropout_ff;
      max_misorder_in = max_misorder_ff;
      min_seq_in      = min_seq_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            rrs_pkg::CSR_MAX_DROPOUT:    max_dropout_in  = csr_write_data;
            rrs_pkg::CSR_MAX_MISORDER:   max_misorder_in = csr_write_data;
            rrs_pkg::CSR_MIN_SEQUENTIAL: min_seq_in      = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in         = item_ff;
      rsp_in          = rsp_ff;
      ident_in        = ident_ff;
      base_in         = base_ff;
      highest_in      = highest_ff;
      suspect_in      = suspect_ff;
      wrap_in         = wrap_ff;
      rx_total_in     = rx_total_ff;
      rx_before_in    = rx_before_ff;
      exp_before_in   = exp_before_ff;
      prob_left_in    = prob_left_ff;
      last_transit_in = last_transit_ff;
      jitter_in       = jitter_ff;
      lost_in         = lost_ff;
      fraction_in     = fraction_ff;
      status_in       = status_ff;
      transit_in      = transit_ff;
      mag_in          = mag_ff;
      decay_in        = decay_ff;
      expected_in     = expected_ff;
      exp_int_in      = exp_int_ff;
      rec_int_in      = rec_int_ff;
      lost_int_in     = lost_int_ff;

      unique case (cmd.op)
         rrs_pkg::OP_CAPTURE: begin
            item_in   = req_payload;
            status_in = 1'b0;
         end
         rrs_pkg::OP_INIT: begin
            base_in       = seq;
            highest_in    = seq - 16'd1;
            suspect_in    = rrs_pkg::NO_SUSPECT;
            wrap_in       = '0;
            rx_total_in   = '0;
            rx_before_in  = '0;
            exp_before_in = '0;
            ident_in      = item_ff.source_id;
            prob_left_in  = min_seq_ff;
         end
         rrs_pkg::OP_SEQ: begin
            if (prob_left_ff != 8'd0) begin
               highest_in = seq;
               status_in  = 1'b1;
               if (seq == hi_next) begin
                  prob_left_in = prob_dec;
                  if (prob_dec == 8'd0) begin
                     // Probation passed: restart and count this packet.
                     base_in       = seq;
                     suspect_in    = rrs_pkg::NO_SUSPECT;
                     wrap_in       = '0;
                     rx_total_in   = 32'd1;
                     rx_before_in  = '0;
                     exp_before_in = '0;
                     status_in     = 1'b0;
                  end
               end else begin
                  prob_left_in = (min_seq_ff != 8'd0) ? min_seq_ff - 8'd1 : 8'd0;
               end
            end else if (udelta < max_dropout_ff) begin
               if (seq < highest_ff) begin
                  wrap_in = wrap_ff + 16'd1;
               end
               highest_in  = seq;
               rx_total_in = rx_total_ff + 32'd1;
            end else if ({1'b0, udelta} <= misorder_limit) begin
               if ({1'b0, seq} == suspect_ff) begin
                  // Second packet of a large jump: the sender restarted.
                  base_in       = seq;
                  highest_in    = seq;
                  suspect_in    = rrs_pkg::NO_SUSPECT;
                  wrap_in       = '0;
                  rx_total_in   = 32'd1;
                  rx_before_in  = '0;
                  exp_before_in = '0;
               end else begin
                  suspect_in = {1'b0, seq + 16'd1};
                  status_in  = 1'b1;
               end
            end else begin
               rx_total_in = rx_total_ff + 32'd1;
            end
         end
         rrs_pkg::OP_JIT_TRANSIT: begin
            transit_in = item_ff.arrival_time - item_ff.rtp_timestamp;
         end
         rrs_pkg::OP_JIT_DIFF: begin
            mag_in          = jit_diff[31] ? (~jit_diff) + 32'd1 : jit_diff;
            decay_in        = jit_plus8[32:4];
            last_transit_in = transit_ff;
         end
         rrs_pkg::OP_JIT_SUM: begin
            // The decay never exceeds the old jitter, so the sum is never negative.
            jitter_in = jit_sum[32] ? 32'hFFFF_FFFF : jit_sum[31:0];
         end
         rrs_pkg::OP_LOSS_EXPECT: begin
            expected_in = {wrap_ff, highest_ff} - {16'd0, base_ff} + 32'd1;
         end
         rrs_pkg::OP_LOSS_INTERVAL: begin
            exp_int_in    = expected_ff - exp_before_ff;
            rec_int_in    = rx_total_ff - rx_before_ff;
            lost_in       = expected_ff - rx_total_ff;
            exp_before_in = expected_ff;
            rx_before_in  = rx_total_ff;
         end
         rrs_pkg::OP_LOSS_LOST: begin
            lost_int_in = exp_int_ff - rec_int_ff;
         end
         rrs_pkg::OP_LOSS_DECIDE: begin
            if (frac_zero) begin
               fraction_in = 8'd0;
            end else if (!need_div) begin
               fraction_in = 8'hFF;
            end
         end
         rrs_pkg::OP_DIV_STORE: begin
            fraction_in = div_quotient;
         end
         rrs_pkg::OP_LOAD_OUT: begin
            rsp_in.status           = status_ff;
            rsp_in.source_ident     = ident_ff;
            rsp_in.extended_max_seq = {wrap_ff, highest_ff};
            rsp_in.received_count   = rx_total_ff;
            rsp_in.cumulative_lost  = lost_ff;
            rsp_in.loss_fraction    = fraction_ff;
            rsp_in.jitter_estimate  = jitter_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
      transit_ff  <= transit_in;
      mag_ff      <= mag_in;
      decay_ff    <= decay_in;
      expected_ff <= expected_in;
      exp_int_ff  <= exp_int_in;
      rec_int_ff  <= rec_int_in;
      lost_int_ff <= lost_int_in;
      if (reset) begin
         max_dropout_ff  <= rrs_pkg::RESET_MAX_DROPOUT;
         max_misorder_ff <= rrs_pkg::RESET_MAX_MISORDER;
         min_seq_ff      <= rrs_pkg::RESET_MIN_SEQUENTIAL;
         ident_ff        <= '0;
         base_ff         <= '0;
         highest_ff      <= '0;
         suspect_ff      <= rrs_pkg::NO_SUSPECT;
         wrap_ff         <= '0;
         rx_total_ff     <= '0;
         rx_before_ff    <= '0;
         exp_before_ff   <= '0;
         prob_left_ff    <= '0;
         last_transit_ff <= '0;
         jitter_ff       <= '0;
         lost_ff         <= '0;
         fraction_ff     <= '0;
         status_ff       <= 1'b0;
      end else begin
         max_dropout_ff  <= max_dropout_in;
         max_misorder_ff <= max_misorder_in;
         min_seq_ff      <= min_seq_in;
         ident_ff        <= ident_in;
         base_ff         <= base_in;
         highest_ff      <= highest_in;
         suspect_ff      <= suspect_in;
         wrap_ff         <= wrap_in;
         rx_total_ff     <= rx_total_in;
         rx_before_ff    <= rx_before_in;
         exp_before_ff   <= exp_before_in;
         prob_left_ff    <= prob_left_in;
         last_transit_ff <= last_transit_in;
         jitter_ff       <= jitter_in;
         lost_ff         <= lost_in;
         fraction_ff     <= fraction_in;
         status_ff       <= status_in;
      end
   end

   assign status.need_div = need_div;
   assign status.div_done = div_done;
   assign rsp_payload     = rsp_ff;

endmodule

FILE: rtl/rrs_ctrl.sv
// Controller that sequences each request through the datapath steps.
module rrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  rrs_pkg::func_type   req_func,
   input  logic                rsp_ready,
   input  rrs_pkg::status_type status,
   output logic                req_ready,
   output logic                rsp_valid,
   output rrs_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INIT   = 4'd1;
   localparam logic [3:0] S_SEQ    = 4'd2;
   localparam logic [3:0] S_JIT_A  = 4'd3;
   localparam logic [3:0] S_JIT_B  = 4'd4;
   localparam logic [3:0] S_JIT_C  = 4'd5;
   localparam logic [3:0] S_LOSS_A = 4'd6;
   localparam logic [3:0] S_LOSS_B = 4'd7;
   localparam logic [3:0] S_LOSS_C = 4'd8;
   localparam logic [3:0] S_LOSS_D = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd.op   = rrs_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op = rrs_pkg::OP_CAPTURE;
               case (req_func)
                  rrs_pkg::FUNC_INIT:   state_in = S_INIT;
                  rrs_pkg::FUNC_SEQ:    state_in = S_SEQ;
                  rrs_pkg::FUNC_JITTER: state_in = S_JIT_A;
                  default:              state_in = S_LOSS_A;
               endcase
            end
         end
         S_INIT: begin
            cmd.op   = rrs_pkg::OP_INIT;
            state_in = S_OUT;
         end
         S_SEQ: begin
            cmd.op   = rrs_pkg::OP_SEQ;
            state_in = S_OUT;
         end
         S_JIT_A: begin
            cmd.op   = rrs_pkg::OP_JIT_TRANSIT;
            state_in = S_JIT_B;
         end
         S_JIT_B: begin
            cmd.op   = rrs_pkg::OP_JIT_DIFF;
            state_in = S_JIT_C;
         end
         S_JIT_C: begin
            cmd.op   = rrs_pkg::OP_JIT_SUM;
            state_in = S_OUT;
         end
         S_LOSS_A: begin
            cmd.op   = rrs_pkg::OP_LOSS_EXPECT;
            state_in = S_LOSS_B;
         end
         S_LOSS_B: begin
            cmd.op   = rrs_pkg::OP_LOSS_INTERVAL;
            state_in = S_LOSS_C;
         end
         S_LOSS_C: begin
            cmd.op   = rrs_pkg::OP_LOSS_LOST;
            state_in = S_LOSS_D;
         end
         S_LOSS_D: begin
            cmd.op   = rrs_pkg::OP_LOSS_DECIDE;
            state_in = status.need_div ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.op   = rrs_pkg::OP_DIV_STORE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.op   = rrs_pkg::OP_LOAD_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rrs_pkg::OP_LOAD_OUT) |-> (!valid_ff || rsp_ready))
      else $error("response register loaded while still holding a result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new request taken while one is still in progress");

   a_result_from_out_state: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside the output step");

endmodule

FILE: rtl/rtp_receiver_statistics.sv
// Top level of the RTP receiver statistics block: controller plus datapath.
//
// The block keeps the receive statistics of one RTP source. Each request on
// req_chan carries a function code: init starts a source and its probation,
// a sequence update checks a packet's sequence number, a jitter update folds
// one packet's timestamp and arrival time into the interarrival jitter, and a
// loss report computes cumulative loss and the loss fraction since the last
// report. Every request produces exactly one response on rsp_chan carrying
// the status of the request and a snapshot of the source state after it.
// One request is in progress at a time. An init or sequence update runs its
// own step, a jitter update the transit, difference and sum steps, and a
// loss report the expect, interval, lost and decide steps and, when the loss
// fraction goes through the divider, a wait for the divider, which retires
// one quotient bit per cycle. A finished response waits in the output
// register; the block accepts the next request while that response is not
// yet taken and only stalls at the next request's end if it is still held.
// Synchronous reset clears the source state and loads the default
// configuration. The csr port writes the gap limits and probation length
// and should be used only while no request is in progress.
module rtp_receiver_statistics (
   input  logic                   clock,
   input  logic                   reset,
   rrs_stream_if.sink             req_chan,
   rrs_stream_if.source           rsp_chan,
   input  logic                   csr_write_en,
   input  rrs_pkg::csr_index_type csr_index,
   input  logic [rrs_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   rrs_pkg::cmd_type         cmd;
   rrs_pkg::status_type      status;
   rrs_pkg::req_payload_type req_payload;
   rrs_pkg::rsp_payload_type rsp_payload;
   logic                     req_ready;
   logic                     rsp_valid;

   assign req_payload = req_chan.payload;

   // Controller owns the handshakes; one command per cycle, none while it waits.
   rrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_payload.func),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the source state, configuration and output register.
   rrs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .status         (status),
      .rsp_payload    (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule
